/* hdl/pcm_linear_interp_resampler_defines.svh */
// ----------------------------------------------------------------------------
// pcm_linear_interp_resampler_defines
// Assertion macros used by the resampler back end (plir_back).
// ----------------------------------------------------------------------------
`ifndef PCM_LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define PCM_LINEAR_INTERP_RESAMPLER_DEFINES_SVH

`ifndef SYNTHESIS
`define PLIR_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("plir assertion failed");
`define PLIR_ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("plir forbidden condition");
`else
`define PLIR_ASSERT(lbl, ck, rn, prop)
`define PLIR_ASSERT_NEVER(lbl, ck, rn, cond)
`endif

`endif

/* hdl/plir_pkg.sv */
// ----------------------------------------------------------------------------
// plir_pkg
// Types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package plir_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 18;
    localparam int CHAN_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W   = 21;
    localparam int MAX_OUT   = 25;
    localparam int CNT_W     = $clog2(MAX_OUT);

    localparam int NUM_W     = RATE_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int PROD_W    = SAMPLE_W + 1 + FRAC_BITS + 1;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int ODEPTH    = 4;
    localparam int OPTR_W    = $clog2(ODEPTH);
    localparam int OCNT_W    = $clog2(ODEPTH + 1);

    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(48000);
    localparam logic [CHAN_W-1:0]  CHAN_RESET = CHAN_W'(2);
    localparam logic [CHAN_W-1:0]  CHAN_MONO  = CHAN_W'(1);
    localparam logic [PHASE_W-1:0] STEP_MAX   = '1;
    localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(1) << FRAC_BITS;
    localparam logic [PHASE_W:0]   ONE_Q      = (PHASE_W + 1)'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_RATE     = 2'd0,
        CFG_DEST_RATE       = 2'd1,
        CFG_SOURCE_CHANNELS = 2'd2,
        CFG_DEST_CHANNELS   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                       prime;
        logic signed [SAMPLE_W-1:0] prev_left;
        logic signed [SAMPLE_W-1:0] prev_right;
        logic signed [SAMPLE_W-1:0] cur_left;
        logic signed [SAMPLE_W-1:0] cur_right;
    } cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } result_t;

endpackage

/* hdl/pcm_linear_interp_resampler.sv */
// An accepted frame passes through the command queue, the product registers and the result queue.
// One result per cycle while the result queue has space; a frame's results issue in order.
// A frame that restarts or primes, or that yields no result, is popped without issuing one.
// A rate write runs the radix-2 step divider: full stays high while the write is pending and the divider is busy.
// Reset (rst_n low, asynchronous) restores 48 kHz stereo both ways, a phase step of 1.0,
// zero previous frame and phase, unprimed state, and empties both queues; no clearing pass.
// ----------------------------------------------------------------------------
// pcm_linear_interp_resampler
// Linear interpolation sample rate converter for 16-bit stereo PCM frames.
// ----------------------------------------------------------------------------
module pcm_linear_interp_resampler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [plir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [plir_pkg::RATE_W-1:0]          cfg_wdata,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [plir_pkg::SAMPLE_W-1:0] sample_left,
    input  logic signed [plir_pkg::SAMPLE_W-1:0] sample_right,
    input  logic                                 restart,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [plir_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [plir_pkg::SAMPLE_W-1:0] out_right,
    output logic                                 last_in_run
);
    import plir_pkg::*;

    cmd_t               cmd_in;
    cmd_t               cmd_head;
    logic               cmd_push;
    logic               cmd_pop;
    logic               cmd_valid;
    logic               q_full;
    logic [PHASE_W-1:0] step;

    plir_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .restart      (restart),
        .full         (full),
        .q_full       (q_full),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in),
        .step         (step)
    );

    plir_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (q_full),
        .pop   (cmd_pop),
        .dout  (cmd_head),
        .valid (cmd_valid)
    );

    plir_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd_head),
        .step        (step),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .out_left    (out_left),
        .out_right   (out_right),
        .last_in_run (last_in_run)
    );

endmodule

/* hdl/plir_step_div.sv */
// ----------------------------------------------------------------------------
// plir_step_div
// Radix-2 restoring divider for the phase step, saturated to the step width.
// ----------------------------------------------------------------------------
module plir_step_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [plir_pkg::RATE_W-1:0]   numer_rate,
    input  logic [plir_pkg::RATE_W-1:0]   denom_rate,
    output logic                          busy,
    output logic [plir_pkg::PHASE_W-1:0]  step
);
    import plir_pkg::*;

    logic                  busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NUM_W-1:0]      quo_reg, quo_next;
    logic [RATE_W-1:0]     rem_reg, rem_next;
    logic [RATE_W-1:0]     den_reg, den_next;
    logic [PHASE_W-1:0]    step_reg, step_next;

    logic [RATE_W:0]       trial;
    logic [RATE_W:0]       trial_diff;
    logic                  trial_ge;
    logic [NUM_W-1:0]      quo_shift;

    assign trial      = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_ge   = trial >= {1'b0, den_reg};
    assign trial_diff = trial - {1'b0, den_reg};
    assign quo_shift  = {quo_reg[NUM_W-2:0], trial_ge};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_W);
            quo_next  = {numer_rate, {FRAC_BITS{1'b0}}};
            rem_next  = '0;
            den_next  = denom_rate;
        end
        else if (busy_reg)
        begin
            quo_next = quo_shift;
            rem_next = trial_ge ? trial_diff[RATE_W-1:0] : trial[RATE_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                step_next = (|quo_shift[NUM_W-1:PHASE_W]) ? STEP_MAX
                                                         : quo_shift[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            step_reg <= STEP_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign step = step_reg;

endmodule

/* hdl/plir_front.sv */
// ----------------------------------------------------------------------------
// plir_front
// Configuration registers, input acceptance, priming and command build.
// ----------------------------------------------------------------------------
module plir_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [plir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [plir_pkg::RATE_W-1:0]          cfg_wdata,
    input  logic                                 push,
    input  logic signed [plir_pkg::SAMPLE_W-1:0] sample_left,
    input  logic signed [plir_pkg::SAMPLE_W-1:0] sample_right,
    input  logic                                 restart,
    output logic                                 full,
    input  logic                                 q_full,
    output logic                                 cmd_push,
    output plir_pkg::cmd_t                       cmd,
    output logic [plir_pkg::PHASE_W-1:0]         step
);
    import plir_pkg::*;

    logic [RATE_W-1:0]          src_rate_reg, src_rate_next;
    logic [RATE_W-1:0]          dst_rate_reg, dst_rate_next;
    logic [CHAN_W-1:0]          src_ch_reg, src_ch_next;
    logic [CHAN_W-1:0]          dst_ch_reg, dst_ch_next;
    logic                       pend_reg, pend_next;
    logic                       primed_reg, primed_next;
    logic signed [SAMPLE_W-1:0] prev_l_reg, prev_l_next;
    logic signed [SAMPLE_W-1:0] prev_r_reg, prev_r_next;

    logic                       div_busy;
    logic                       accept;
    logic                       mono;

    plir_step_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (pend_reg),
        .numer_rate (src_rate_reg),
        .denom_rate (dst_rate_reg),
        .busy       (div_busy),
        .step       (step)
    );

    assign full   = pend_reg || div_busy || q_full;
    assign accept = push && !full;
    assign mono   = (src_ch_reg == CHAN_MONO) || (dst_ch_reg == CHAN_MONO);

    always_comb
    begin
        src_rate_next = src_rate_reg;
        dst_rate_next = dst_rate_reg;
        src_ch_next   = src_ch_reg;
        dst_ch_next   = dst_ch_reg;
        pend_next     = 1'b0;
        if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SOURCE_RATE:
                begin
                    src_rate_next = cfg_wdata;
                    pend_next     = 1'b1;
                end
                CFG_DEST_RATE:
                begin
                    dst_rate_next = cfg_wdata;
                    pend_next     = 1'b1;
                end
                CFG_SOURCE_CHANNELS: src_ch_next = cfg_wdata[CHAN_W-1:0];
                CFG_DEST_CHANNELS:   dst_ch_next = cfg_wdata[CHAN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        cmd.prime      = restart || !primed_reg;
        cmd.prev_left  = prev_l_reg;
        cmd.cur_left   = sample_left;
        cmd.prev_right = mono ? prev_l_reg  : prev_r_reg;
        cmd.cur_right  = mono ? sample_left : sample_right;
        cmd_push       = accept;
        primed_next    = primed_reg || accept;
        prev_l_next    = accept ? sample_left  : prev_l_reg;
        prev_r_next    = accept ? sample_right : prev_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_rate_reg <= RATE_RESET;
            dst_rate_reg <= RATE_RESET;
            src_ch_reg   <= CHAN_RESET;
            dst_ch_reg   <= CHAN_RESET;
            pend_reg     <= 1'b0;
            primed_reg   <= 1'b0;
            prev_l_reg   <= '0;
            prev_r_reg   <= '0;
        end
        else
        begin
            src_rate_reg <= src_rate_next;
            dst_rate_reg <= dst_rate_next;
            src_ch_reg   <= src_ch_next;
            dst_ch_reg   <= dst_ch_next;
            pend_reg     <= pend_next;
            primed_reg   <= primed_next;
            prev_l_reg   <= prev_l_next;
            prev_r_reg   <= prev_r_next;
        end
    end

endmodule

/* hdl/plir_cmd_queue.sv */
// ----------------------------------------------------------------------------
// plir_cmd_queue
// Short command queue between the front and the interpolation back end.
// ----------------------------------------------------------------------------
module plir_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  plir_pkg::cmd_t din,
    output logic           full,
    input  logic           pop,
    output plir_pkg::cmd_t dout,
    output logic           valid
);
    import plir_pkg::*;

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full    = cnt_reg == QCNT_W'(QDEPTH);
    assign valid   = cnt_reg != '0;
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

/* hdl/plir_back.sv */
// ----------------------------------------------------------------------------
// plir_back
// Phase sequencer, interpolation multiply/add pipeline and result queue.
// ----------------------------------------------------------------------------
`include "pcm_linear_interp_resampler_defines.svh"

module plir_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  plir_pkg::cmd_t                       cmd,
    input  logic [plir_pkg::PHASE_W-1:0]         step,
    output logic                                 cmd_pop,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [plir_pkg::SAMPLE_W-1:0] out_left,
    output logic signed [plir_pkg::SAMPLE_W-1:0] out_right,
    output logic                                 last_in_run
);
    import plir_pkg::*;

    // phase sequencer
    logic [PHASE_W:0]           phase_reg, phase_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [PHASE_W:0]           phase_sum;
    logic [PHASE_W:0]           sum_wrap;
    logic [PHASE_W:0]           phase_wrap;
    logic                       below_one;
    logic                       sum_ge;
    logic                       run_last;
    logic                       is_run;
    logic                       space;
    logic                       issue;

    // multiply stage
    logic signed [SAMPLE_W:0]    diff_l;
    logic signed [SAMPLE_W:0]    diff_r;
    logic signed [FRAC_BITS:0]   frac_op;
    logic signed [PROD_W-1:0]    prod_l;
    logic signed [PROD_W-1:0]    prod_r;
    logic                        pv_reg;
    logic signed [PROD_W-1:0]    prod_l_reg;
    logic signed [PROD_W-1:0]    prod_r_reg;
    logic signed [SAMPLE_W-1:0]  base_l_reg;
    logic signed [SAMPLE_W-1:0]  base_r_reg;
    logic                        plast_reg;

    // add stage
    logic signed [PROD_W-1:0]    shr_l;
    logic signed [PROD_W-1:0]    shr_r;
    logic signed [SAMPLE_W+1:0]  sum_l;
    logic signed [SAMPLE_W+1:0]  sum_r;
    result_t                     res_in;

    // result queue
    result_t                     res_mem [ODEPTH];
    logic [OPTR_W-1:0]           owr_reg, owr_next;
    logic [OPTR_W-1:0]           ord_reg, ord_next;
    logic [OCNT_W-1:0]           ocount_reg, ocount_next;
    logic                        do_rd;

    assign phase_sum  = phase_reg + {1'b0, step};
    assign sum_wrap   = phase_sum - ONE_Q;
    assign phase_wrap = phase_reg - ONE_Q;
    assign below_one  = phase_reg < ONE_Q;
    assign sum_ge     = phase_sum >= ONE_Q;
    assign run_last   = sum_ge || (cnt_reg == CNT_W'(MAX_OUT - 1));
    assign is_run     = cmd_valid && !cmd.prime;
    assign space      = ((OCNT_W + 1)'(ocount_reg) + (OCNT_W + 1)'(pv_reg))
                        < (OCNT_W + 1)'(ODEPTH);
    assign issue      = is_run && below_one && space;
    assign cmd_pop    = cmd_valid && (cmd.prime || !below_one || (issue && run_last));

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (cmd_valid && cmd.prime)
        begin
            phase_next = '0;
        end
        else if (is_run && !below_one)
        begin
            phase_next = {1'b0, phase_wrap[PHASE_W-1:0]};
        end
        else if (issue)
        begin
            if (!run_last)
            begin
                phase_next = phase_sum;
            end
            else if (sum_ge)
            begin
                phase_next = {1'b0, sum_wrap[PHASE_W-1:0]};
            end
            else
            begin
                phase_next = '0;
            end
        end
        if (cmd_pop)
        begin
            cnt_next = '0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    assign frac_op = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});
    assign diff_l  = $signed({cmd.cur_left[SAMPLE_W-1], cmd.cur_left})
                   - $signed({cmd.prev_left[SAMPLE_W-1], cmd.prev_left});
    assign diff_r  = $signed({cmd.cur_right[SAMPLE_W-1], cmd.cur_right})
                   - $signed({cmd.prev_right[SAMPLE_W-1], cmd.prev_right});
    assign prod_l  = diff_l * frac_op;
    assign prod_r  = diff_r * frac_op;

    assign shr_l = prod_l_reg >>> FRAC_BITS;
    assign shr_r = prod_r_reg >>> FRAC_BITS;
    assign sum_l = $signed({{2{base_l_reg[SAMPLE_W-1]}}, base_l_reg}) + shr_l[SAMPLE_W+1:0];
    assign sum_r = $signed({{2{base_r_reg[SAMPLE_W-1]}}, base_r_reg}) + shr_r[SAMPLE_W+1:0];

    always_comb
    begin
        res_in.left  = sum_l[SAMPLE_W-1:0];
        res_in.right = sum_r[SAMPLE_W-1:0];
        res_in.last  = plast_reg;
    end

    assign empty       = ocount_reg == '0;
    assign do_rd       = pop && !empty;
    assign out_left    = res_mem[ord_reg].left;
    assign out_right   = res_mem[ord_reg].right;
    assign last_in_run = res_mem[ord_reg].last;

    always_comb
    begin
        owr_next = owr_reg;
        ord_next = ord_reg;
        if (pv_reg)
        begin
            owr_next = (owr_reg == OPTR_W'(ODEPTH - 1)) ? '0 : owr_reg + OPTR_W'(1);
        end
        if (do_rd)
        begin
            ord_next = (ord_reg == OPTR_W'(ODEPTH - 1)) ? '0 : ord_reg + OPTR_W'(1);
        end
        ocount_next = ocount_reg + OCNT_W'(pv_reg) - OCNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            cnt_reg    <= '0;
            pv_reg     <= 1'b0;
            owr_reg    <= '0;
            ord_reg    <= '0;
            ocount_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            pv_reg     <= issue;
            owr_reg    <= owr_next;
            ord_reg    <= ord_next;
            ocount_reg <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_l_reg <= prod_l;
            prod_r_reg <= prod_r;
            base_l_reg <= cmd.prev_left;
            base_r_reg <= cmd.prev_right;
            plast_reg  <= run_last;
        end
        if (pv_reg)
        begin
            res_mem[owr_reg] <= res_in;
        end
    end

    `PLIR_ASSERT_NEVER(a_ofifo_overrun, clk, rst_n, pv_reg && (ocount_reg == OCNT_W'(ODEPTH)))
    `PLIR_ASSERT(a_cnt_cap, clk, rst_n, cnt_reg < CNT_W'(MAX_OUT))
    `PLIR_ASSERT(a_prime_zero_phase, clk, rst_n, (cmd_valid && cmd.prime) |=> (phase_reg == '0))
    `PLIR_ASSERT(a_rest_phase_range, clk, rst_n, (cnt_reg == '0) |-> !phase_reg[PHASE_W])

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear interpolation resampler. A directed table
// covers sample extremes, restart, mono on either side, upsampling to the
// output cap, downsampling and saturated phase steps. A random run over many
// rate and channel settings follows. Every result beat is compared against a
// cycle-free model of the converter, or the table value for typed rows, while
// the sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import plir_pkg::*;

    localparam int RANDOM_FRAMES  = 320;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_ROWS         = 43;

    typedef enum logic {ROW_REG, ROW_FRAME} row_kind_t;
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_RUNS} rx_mode_t;

    typedef struct packed {
        row_kind_t               kind;
        cfg_index_t              idx;
        logic [RATE_W-1:0]       value;
        logic [SAMPLE_W-1:0]     left;
        logic [SAMPLE_W-1:0]     right;
        logic                    rs;
        logic                    typed;
        logic [SAMPLE_W-1:0]     exp_left;
        logic [SAMPLE_W-1:0]     exp_right;
    } dir_row_t;

    // typed rows run at 48k/48k stereo: one beat per frame, equal to the previous frame
    localparam dir_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 16'h7FFF, 16'h8000},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 16'h8000, 16'h7FFF},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h3039, 16'hCFC7, 1'b0, 1'b1, 16'hFFFF, 16'h0000},
        '{ROW_REG, CFG_SOURCE_CHANNELS, 18'd1, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h03E8, 16'hEC78, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_SOURCE_RATE, 18'd8000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_RATE, 18'd192000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_SOURCE_CHANNELS, 18'd3, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_CHANNELS, 18'd1, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_CHANNELS, 18'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h1234, 16'hEDCB, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_SOURCE_RATE, 18'd192000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_RATE, 18'd8000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h0100, 16'hFF00, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_RATE, 18'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h1111, 16'h2222, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h3333, 16'h4444, 1'b1, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h5555, 16'h6666, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h7777, 16'h8888, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_SOURCE_RATE, 18'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_RATE, 18'd48000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_SOURCE_CHANNELS, 18'd0, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_CHANNELS, 18'd3, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_SOURCE_RATE, 18'd262143, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_RATE, 18'd8000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h0F0F, 16'hF0F0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'hF0F0, 16'h0F0F, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_SOURCE_RATE, 18'd48000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_RATE, 18'd48000, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_SOURCE_CHANNELS, 18'd2, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_REG, CFG_DEST_CHANNELS, 18'd2, 16'h0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'hABCD, 16'h1234, 1'b0, 1'b0, 16'h0, 16'h0},
        '{ROW_FRAME, CFG_SOURCE_RATE, 18'd0, 16'h4321, 16'hDCBA, 1'b0, 1'b0, 16'h0, 16'h0}
    };

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_wen      = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = CFG_SOURCE_RATE;
    logic [RATE_W-1:0]          cfg_wdata    = '0;
    logic                       push         = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample_left  = '0;
    logic signed [SAMPLE_W-1:0] sample_right = '0;
    logic                       restart      = 1'b0;
    logic                       empty;
    logic                       pop          = 1'b0;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_in_run;

    // converter model state, matching the block after reset
    logic [RATE_W-1:0]          reg_source_rate     = RATE_RESET;
    logic [RATE_W-1:0]          reg_dest_rate       = RATE_RESET;
    logic [CHAN_W-1:0]          reg_source_channels = CHAN_RESET;
    logic [CHAN_W-1:0]          reg_dest_channels   = CHAN_RESET;
    logic signed [SAMPLE_W-1:0] pred_prev_left      = '0;
    logic signed [SAMPLE_W-1:0] pred_prev_right     = '0;
    logic [PHASE_W-1:0]         pred_phase          = '0;
    logic                       pred_primed         = 1'b0;
    logic [PHASE_W-1:0]         pred_step           = STEP_RESET;

    result_t  pred_run[$];
    result_t  expected_frames[$];
    int       mismatches     = 0;
    int       burst_left     = 0;
    int       stalled_cycles = 0;
    int       rx_count       = 0;
    int       rx_hold        = 0;
    logic     rx_level       = 1'b1;
    rx_mode_t rx_mode        = RX_FREE;

    pcm_linear_interp_resampler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .restart      (restart),
        .empty        (empty),
        .pop          (pop),
        .out_left     (out_left),
        .out_right    (out_right),
        .last_in_run  (last_in_run)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [PHASE_W-1:0] rate_to_step(input logic [RATE_W-1:0] src,
                                                        input logic [RATE_W-1:0] dst);
        logic [NUM_W-1:0] quo;
        if (dst == '0)
        begin
            return STEP_MAX;
        end
        quo = (NUM_W'(src) << FRAC_BITS) / NUM_W'(dst);
        return (quo > NUM_W'(STEP_MAX)) ? STEP_MAX : quo[PHASE_W-1:0];
    endfunction

    // a + floor((b - a) * frac / 2^FRAC_BITS)
    function automatic logic signed [SAMPLE_W-1:0] interp_sample(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [FRAC_BITS-1:0]       frac);
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'(frac);
        return SAMPLE_W'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    function automatic void predict_frame(input logic signed [SAMPLE_W-1:0] l,
                                          input logic signed [SAMPLE_W-1:0] r,
                                          input logic rs);
        logic [23:0] ph;
        logic [23:0] nxt;
        int          n;
        result_t     res;
        pred_run.delete();
        if (rs || !pred_primed)
        begin
            pred_prev_left  = l;
            pred_prev_right = r;
            pred_phase      = '0;
            pred_primed     = 1'b1;
            return;
        end
        ph = 24'(pred_phase);
        n  = 0;
        while (ph < 24'(ONE_Q) && n < MAX_OUT)
        begin
            res.left  = interp_sample(pred_prev_left, l, ph[FRAC_BITS-1:0]);
            res.right = (reg_source_channels == CHAN_MONO) ? res.left :
                        interp_sample(pred_prev_right, r, ph[FRAC_BITS-1:0]);
            if (reg_dest_channels == CHAN_MONO)
            begin
                res.right = res.left;
            end
            nxt = ph + 24'(pred_step);
            n++;
            res.last = (nxt >= 24'(ONE_Q)) || (n == MAX_OUT);
            pred_run = {pred_run, res};
            ph = nxt;
        end
        // output cap hit: phase snaps to 1.0
        if (ph < 24'(ONE_Q))
        begin
            ph = 24'(ONE_Q);
        end
        pred_phase      = PHASE_W'(ph - 24'(ONE_Q));
        pred_prev_left  = l;
        pred_prev_right = r;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        if ($urandom_range(0, 7) != 0)
        begin
            return RATE_W'($urandom_range(8000, 192000));
        end
        case ($urandom_range(0, 5))
            0:       return RATE_W'(0);
            1:       return RATE_W'(1);
            2:       return RATE_W'(8000);
            3:       return RATE_W'(192000);
            4:       return '1;
            default: return RATE_W'(44100);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(0, 7) != 0)
        begin
            return SAMPLE_W'($urandom);
        end
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // hold off until nothing is in flight and the step divider is done
    task automatic quiesce();
        push <= 1'b0;
        while (expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [RATE_W-1:0] value);
        quiesce();
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_wen   <= 1'b1;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_SOURCE_RATE:     reg_source_rate     = value;
            CFG_DEST_RATE:       reg_dest_rate       = value;
            CFG_SOURCE_CHANNELS: reg_source_channels = value[CHAN_W-1:0];
            CFG_DEST_CHANNELS:   reg_dest_channels   = value[CHAN_W-1:0];
            default: ;
        endcase
        pred_step = rate_to_step(reg_source_rate, reg_dest_rate);
    endtask

    task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                              input logic rs, input logic typed,
                              input logic [SAMPLE_W-1:0] el, input logic [SAMPLE_W-1:0] er);
        result_t typed_res;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
                                                       $urandom_range(1, 16);
        end
        sample_left  <= l;
        sample_right <= r;
        restart      <= rs;
        push         <= 1'b1;
        do
            @(posedge clk);
        while (full);
        burst_left--;
        predict_frame(l, r, rs);
        if (typed)
        begin
            typed_res = '{left: el, right: er, last: 1'b1};
            expected_frames = {expected_frames, typed_res};
        end
        else
        begin
            foreach (pred_run[k])
            begin
                expected_frames = {expected_frames, pred_run[k]};
            end
        end
    endtask

    // receiver: free-running, coin-flip or long on/off runs, with the mode picked anew at random
    always @(posedge clk)
    begin
        rx_count++;
        if (rx_count % 256 == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
        end
        case (rx_mode)
            RX_FREE: pop <= 1'b1;
            RX_COIN: pop <= ($urandom_range(0, 1) == 1);
            default:
            begin
                if (rx_hold == 0)
                begin
                    rx_level = !rx_level;
                    rx_hold  = $urandom_range(1, 20);
                end
                else
                begin
                    rx_hold--;
                end
                pop <= rx_level;
            end
        endcase
    end

    always @(posedge clk)
    begin : check_beat
        result_t exp_res;
        if (rst_n && pop && !empty)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%t: unexpected beat left=%0d right=%0d last=%0b",
                         $time, out_left, out_right, last_in_run);
                mismatches++;
            end
            else
            begin
                exp_res = expected_frames.pop_front();
                if (out_left !== exp_res.left)
                begin
                    $display("%t: out_left expected %0d got %0d",
                             $time, exp_res.left, out_left);
                    mismatches++;
                end
                if (out_right !== exp_res.right)
                begin
                    $display("%t: out_right expected %0d got %0d",
                             $time, exp_res.right, out_right);
                    mismatches++;
                end
                if (last_in_run !== exp_res.last)
                begin
                    $display("%t: last_in_run expected %0b got %0b",
                             $time, exp_res.last, last_in_run);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            stalled_cycles <= 0;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%t: watchdog, no beat for %0d cycles", $time, stalled_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int sent;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_REG)
            begin
                write_reg(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value);
            end
            else
            begin
                send_frame(DIRECTED_ROWS[i].left, DIRECTED_ROWS[i].right,
                           DIRECTED_ROWS[i].rs, DIRECTED_ROWS[i].typed,
                           DIRECTED_ROWS[i].exp_left, DIRECTED_ROWS[i].exp_right);
            end
        end

        while (sent < RANDOM_FRAMES)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_SOURCE_RATE, pick_rate());
            end
            if ($urandom_range(0, 1) == 1)
            begin
                write_reg(CFG_DEST_RATE, pick_rate());
            end
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(CFG_SOURCE_CHANNELS, RATE_W'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(CFG_DEST_CHANNELS, RATE_W'($urandom_range(0, 3)));
            end
            repeat ($urandom_range(20, 50))
            begin
                send_frame(pick_sample(), pick_sample(), ($urandom_range(0, 19) == 0),
                           1'b0, '0, '0);
                sent++;
            end
        end

        push <= 1'b0;
        while (expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/plir_pkg.sv
hdl/plir_step_div.sv
hdl/plir_front.sv
hdl/plir_cmd_queue.sv
hdl/plir_back.sv
hdl/pcm_linear_interp_resampler.sv
tb/sv/testbench.sv
